@@ hw/rtl/bf3_pkg.sv @@
// ---------------------------------------------------------------------------
// bf3_pkg: shared types and constants of the 3x3 box filter
// Widths of the pixel, coordinate and register fields, the register indexes,
// the reciprocal used for the divide by nine, and the job passed from the
// front end to the back end.
// ---------------------------------------------------------------------------
`default_nettype none

package bf3_pkg;

	// line store depth, the column widths that follow from it and the other widths
	localparam int MaxWidth   = 1024;
	localparam int ColW       = $clog2(MaxWidth);
	localparam int RowW       = 12;
	localparam int PixW       = 8;
	localparam int WidthRegW  = ColW + 1;
	localparam int HeightRegW = 12;
	localparam int CfgDataW   = 12;
	localparam int CfgIdxW    = 2;

	// register indexes
	localparam logic [CfgIdxW-1:0] RegImageWidth  = 2'd0;
	localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd1;

	// register reset values and the smallest legal frame side
	localparam logic [WidthRegW-1:0]  WidthReset  = WidthRegW'(130);
	localparam logic [HeightRegW-1:0] HeightReset = HeightRegW'(98);
	localparam int                    MinSide     = 3;

	// job queue depth
	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = $clog2(QueueDepth);

	// sum of nine pixels and divide by nine as multiply and shift
	localparam int                SumW       = PixW + 4;
	localparam int                RecipW     = 13;
	localparam logic [RecipW-1:0] RecipNine  = 13'd7282;
	localparam int                RecipShift = 16;
	localparam int                ProdW      = SumW + RecipW;

	typedef logic [PixW-1:0] pix_t;

	// window: row 0 oldest line, column 0 oldest column
	typedef pix_t [2:0][2:0] win_t;

	// one input position with its window and output classification
	typedef struct packed {
		win_t            win;
		logic [ColW-1:0] col;
		logic [RowW-1:0] row;
		logic            xp_any;   // column c-1 is released
		logic            xp_full;  // column c-2 exists
		logic            x_edge;   // last column of the row
		logic            yp_any;   // row r-1 is released
		logic            yp_full;  // row r-2 exists
		logic            y_edge;   // last row of the frame
	} job_t;

endpackage

`default_nettype wire

@@ hw/rtl/bf3_front.sv @@
// ---------------------------------------------------------------------------
// bf3_front: pixel intake, line store and window
// Keeps the frame position and the configuration registers, reads the two
// stored lines for each pixel, shifts the window and hands a classified job
// to the queue for every position that releases outputs.
// ---------------------------------------------------------------------------
`default_nettype none

module bf3_front import bf3_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [PixW-1:0]     pixel,
	input  wire logic                cfg_write_en,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	input  wire logic                q_full,
	output logic                     q_push,
	output job_t                     q_job
);

	logic [WidthRegW-1:0]  width_q;
	logic [HeightRegW-1:0] height_q;
	logic [ColW-1:0]       col_q;
	logic [RowW-1:0]       row_q;
	logic [ColW-1:0]       col_last;
	logic [RowW-1:0]       row_last;

	logic                  s1_valid_s1;
	pix_t                  pix_s1;
	logic [ColW-1:0]       col_s1;
	logic [RowW-1:0]       row_s1;
	logic                  xp_any_s1, xp_full_s1, x_edge_s1;
	logic                  yp_any_s1, yp_full_s1, y_edge_s1;
	logic [2*PixW-1:0]     rd_s1;

	// each word: upper line in the high byte, lower line in the low byte
	logic [2*PixW-1:0]     line_mem [MaxWidth];

	win_t                  win_q;
	win_t                  win_next;
	logic                  accept;
	logic                  advance;
	logic                  at_row_end;
	logic                  at_frame_end;

	// effective frame size, clamped to the legal range
	always_comb begin
		logic [WidthRegW-1:0]  w_eff;
		logic [HeightRegW-1:0] h_eff;
		w_eff = width_q;
		if (width_q < WidthRegW'(MinSide)) begin
			w_eff = WidthRegW'(MinSide);
		end else if (width_q > WidthRegW'(MaxWidth)) begin
			w_eff = WidthRegW'(MaxWidth);
		end
		h_eff = height_q;
		if (height_q < HeightRegW'(MinSide)) begin
			h_eff = HeightRegW'(MinSide);
		end
		col_last = ColW'(w_eff - WidthRegW'(1));
		row_last = RowW'(h_eff - HeightRegW'(1));
	end

	assign in_stall     = s1_valid_s1 && q_full;
	assign accept       = in_valid && !in_stall;
	assign advance      = s1_valid_s1 && !q_full;
	assign at_row_end   = (col_q == col_last);
	assign at_frame_end = (row_q == row_last);

	// configuration registers and frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WidthReset;
			height_q <= HeightReset;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_write_en && (cfg_index == RegImageWidth ||
				cfg_index == RegImageHeight)) begin
			if (cfg_index == RegImageWidth) begin
				width_q <= WidthRegW'(cfg_data);
			end else begin
				height_q <= cfg_data;
			end
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (at_row_end) begin
				col_q <= '0;
				row_q <= at_frame_end ? '0 : row_q + RowW'(1);
			end else begin
				col_q <= col_q + ColW'(1);
			end
		end
	end

	// intake stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (advance) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	// intake stage payload and classification
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= pixel;
			col_s1     <= col_q;
			row_s1     <= row_q;
			xp_any_s1  <= (col_q != '0);
			xp_full_s1 <= (col_q > ColW'(1));
			x_edge_s1  <= at_row_end;
			yp_any_s1  <= (row_q != '0);
			yp_full_s1 <= (row_q > RowW'(1));
			y_edge_s1  <= at_frame_end;
		end
	end

	// line store: read at intake, write back when the stage moves on
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= line_mem[col_q];
		end
		if (advance) begin
			line_mem[col_s1] <= {rd_s1[PixW-1:0], pix_s1};
		end
	end

	// window shifted by one column
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_next[i][0] = win_q[i][1];
			win_next[i][1] = win_q[i][2];
		end
		win_next[0][2] = rd_s1[2*PixW-1:PixW];
		win_next[1][2] = rd_s1[PixW-1:0];
		win_next[2][2] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (advance) begin
			win_q <= win_next;
		end
	end

	// job to the queue, only where outputs are released
	assign q_push = advance && (xp_any_s1 || x_edge_s1) && (yp_any_s1 || y_edge_s1);

	always_comb begin
		q_job.win     = win_next;
		q_job.col     = col_s1;
		q_job.row     = row_s1;
		q_job.xp_any  = xp_any_s1;
		q_job.xp_full = xp_full_s1;
		q_job.x_edge  = x_edge_s1;
		q_job.yp_any  = yp_any_s1;
		q_job.yp_full = yp_full_s1;
		q_job.y_edge  = y_edge_s1;
	end

endmodule

`default_nettype wire

@@ hw/rtl/bf3_queue.sv @@
// ---------------------------------------------------------------------------
// bf3_queue: job queue between front and back end
// Small first-in first-out store of classified jobs so that the pixel side
// and the result side stall independently.
// ---------------------------------------------------------------------------
`default_nettype none

module bf3_queue import bf3_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	input  wire logic pop,
	output job_t      head_job,
	output logic      head_valid
);

	job_t                 slot_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q;
	logic [QueuePtrW-1:0] rd_ptr_q;
	logic [QueuePtrW:0]   count_q;

	assign full       = (count_q == (QueuePtrW+1)'(QueueDepth));
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QueuePtrW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QueuePtrW+1)'(1);
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/bf3_back.sv @@
// ---------------------------------------------------------------------------
// bf3_back: result sequencer and mean unit
// Walks the one to four outputs of the job at the queue head, one per cycle
// unless stalled, sums the clamped neighbourhood, divides by nine with a
// reciprocal multiply, holding each result in the output register until taken.
// ---------------------------------------------------------------------------
`default_nettype none

module bf3_back import bf3_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire job_t         head_job,
	input  wire logic         head_valid,
	output logic              pop,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [PixW-1:0]   mean_value,
	output logic [ColW-1:0]   out_col,
	output logic [RowW-1:0]   out_row,
	output logic              last_of_run,
	output logic              end_of_frame
);

	logic            a_q;   // second output row of the job
	logic            b_q;   // second output column of the job
	logic            adv;
	logic            emit;
	logic            x_two, y_two;
	logic            end_b, end_a;
	logic            x_is_edge, y_is_edge;
	logic [1:0]      ri [3];
	logic [1:0]      cj [3];
	logic [SumW-1:0] sum;
	logic [ColW-1:0] x_cur;
	logic [RowW-1:0] y_cur;

	logic            valid_s1;
	logic [SumW-1:0] sum_s1;
	logic [ColW-1:0] col_s1;
	logic [RowW-1:0] row_s1;
	logic            last_s1;
	logic            eof_s1;
	logic [ProdW-1:0] prod;

	// the whole result path moves when the output register is free
	assign adv   = !out_valid || !out_stall;
	assign emit  = head_valid && adv;
	assign x_two = head_job.xp_any && head_job.x_edge;
	assign y_two = head_job.yp_any && head_job.y_edge;
	assign end_b = !x_two || b_q;
	assign end_a = !y_two || a_q;
	assign pop   = emit && end_a && end_b;

	// output order within a job: rows outer, columns inner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= 1'b0;
			b_q <= 1'b0;
		end else if (emit) begin
			if (end_b) begin
				b_q <= 1'b0;
				a_q <= end_a ? 1'b0 : 1'b1;
			end else begin
				b_q <= 1'b1;
			end
		end
	end

	// neighbourhood rows and columns after edge clamping
	assign x_is_edge = b_q || !head_job.xp_any;
	assign y_is_edge = a_q || !head_job.yp_any;

	always_comb begin
		if (y_is_edge) begin
			ri[0] = 2'd1;
			ri[1] = 2'd2;
			ri[2] = 2'd2;
		end else begin
			ri[0] = head_job.yp_full ? 2'd0 : 2'd1;
			ri[1] = 2'd1;
			ri[2] = 2'd2;
		end
		if (x_is_edge) begin
			cj[0] = 2'd1;
			cj[1] = 2'd2;
			cj[2] = 2'd2;
		end else begin
			cj[0] = head_job.xp_full ? 2'd0 : 2'd1;
			cj[1] = 2'd1;
			cj[2] = 2'd2;
		end
	end

	// nine-pixel sum
	always_comb begin
		sum = '0;
		for (int p = 0; p < 3; p++) begin
			for (int q = 0; q < 3; q++) begin
				sum = sum + SumW'(head_job.win[ri[p]][cj[q]]);
			end
		end
	end

	assign x_cur = x_is_edge ? head_job.col : head_job.col - ColW'(1);
	assign y_cur = y_is_edge ? head_job.row : head_job.row - RowW'(1);

	// sum stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sum_s1  <= sum;
			col_s1  <= x_cur;
			row_s1  <= y_cur;
			last_s1 <= end_a && end_b;
			eof_s1  <= x_is_edge && head_job.x_edge && y_is_edge && head_job.y_edge;
		end
	end

	// divide by nine: multiply by the scaled reciprocal and drop the fraction
	assign prod = {{RecipW{1'b0}}, sum_s1} * {{SumW{1'b0}}, RecipNine};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			mean_value   <= prod[RecipShift +: PixW];
			out_col      <= col_s1;
			out_row      <= row_s1;
			last_of_run  <= last_s1;
			end_of_frame <= eof_s1;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/box_filter_3x3_u8.sv @@
// a pixel's results pass the intake stage, the job queue, the sum stage and
// the output register; unless stalled, one pixel per cycle goes in and one
// result per cycle comes out, a pixel's up to 4 results one after another
// the four-entry job queue lets intake run ahead of the result sequencer
// reset clears counters, queue, window and registers to their defaults
// ---------------------------------------------------------------------------
// box_filter_3x3_u8: streaming 3x3 mean filter with replicate border
// Front end with line store and window, a job queue, and a back end that
// produces the truncated mean of each clamped neighbourhood.
// ---------------------------------------------------------------------------
`default_nettype none

module box_filter_3x3_u8 import bf3_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [PixW-1:0]     pixel,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [PixW-1:0]          mean_value,
	output logic [ColW-1:0]          out_col,
	output logic [RowW-1:0]          out_row,
	output logic                     last_of_run,
	output logic                     end_of_frame,
	input  wire logic                cfg_write_en,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	job_t push_job;
	job_t head_job;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic head_valid;

	// pixel intake and window
	bf3_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel        (pixel),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_job        (push_job)
	);

	// job queue
	bf3_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_job   (head_job),
		.head_valid (head_valid)
	);

	// result sequencer and mean
	bf3_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_job     (head_job),
		.head_valid   (head_valid),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mean_value   (mean_value),
		.out_col      (out_col),
		.out_row      (out_row),
		.last_of_run  (last_of_run),
		.end_of_frame (end_of_frame)
	);

endmodule

`default_nettype wire
